[rtl/mlfq_pkg.sv]
// Shared types and constants for the three-level feedback-queue scheduler.
// No dependencies.
package mlfq_pkg;

    localparam int NUM_LEVELS = 3;

    typedef enum logic [1:0] {
        CFG_BOOST_PERIOD = 2'd0,
        CFG_QUANTUM_L0   = 2'd1,
        CFG_QUANTUM_L1   = 2'd2,
        CFG_QUANTUM_L2   = 2'd3
    } cfg_index_t;

    typedef enum logic [0:0] {
        FUNC_ARRIVAL = 1'b0,
        FUNC_TICK    = 1'b1
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_BOOST_RUN,
        ST_BOOST_POP,
        ST_BOOST_PUSH,
        ST_PREEMPT,
        ST_DISPATCH,
        ST_DISP_LOAD,
        ST_SERVE,
        ST_SERVE_WB,
        ST_OUTPUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic arrive;
        logic boost_tick;
        logic boost_runner;
        logic boost_pop;
        logic boost_push;
        logic preempt;
        logic dispatch;
        logic disp_load;
        logic serve;
        logic serve_wb;
        logic present;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic boost_due;
        logic lower_busy;
        logic any_work;
        logic runner_valid;
        logic out_busy;
    } status_t;

endpackage

[rtl/mlfq_ctrl.sv]
// Sequencer for the scheduler: walks each item through its arrival or tick phases.
// Depends on mlfq_pkg.
module mlfq_ctrl import mlfq_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = !stat.out_busy;
                if (in_valid && !stat.out_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ARRIVE;
                end
            end
            ST_ARRIVE: begin
                if (!stat.is_tick) begin
                    cmd.arrive = 1'b1;
                    state_next = ST_OUTPUT;
                end else begin
                    cmd.boost_tick = 1'b1;
                    state_next     = ST_BOOST_RUN;
                end
            end
            ST_BOOST_RUN: begin
                if (stat.boost_due) begin
                    cmd.boost_runner = 1'b1;
                    state_next       = ST_BOOST_POP;
                end else begin
                    state_next = ST_PREEMPT;
                end
            end
            ST_BOOST_POP: begin
                if (stat.lower_busy) begin
                    cmd.boost_pop = 1'b1;
                    state_next    = ST_BOOST_PUSH;
                end else begin
                    state_next = ST_PREEMPT;
                end
            end
            ST_BOOST_PUSH: begin
                cmd.boost_push = 1'b1;
                state_next     = ST_BOOST_POP;
            end
            ST_PREEMPT: begin
                cmd.preempt = 1'b1;
                state_next  = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                state_next   = ST_DISP_LOAD;
            end
            ST_DISP_LOAD: begin
                cmd.disp_load = 1'b1;
                state_next    = ST_SERVE;
            end
            ST_SERVE: begin
                cmd.serve  = 1'b1;
                state_next = ST_SERVE_WB;
            end
            ST_SERVE_WB: begin
                cmd.serve_wb = 1'b1;
                state_next   = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                cmd.present = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/mlfq_dp.sv]
// Datapath for the scheduler: level rings, per-id tables, runner and counters.
// Depends on mlfq_pkg.
module mlfq_dp import mlfq_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               stat,
    input  logic                  in_func,
    input  logic [3:0]            in_proc_id,
    input  logic [15:0]           in_burst,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [15:0]           cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [48:0]           out_data
);

    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    // configuration
    logic [15:0] boost_period_reg;
    logic [7:0]  quantum_reg [NUM_LEVELS];

    // rings
    logic [3:0]  ring_mem [NUM_LEVELS][MAX_PROCS];
    logic [PW-1:0] head_reg [NUM_LEVELS];
    logic [PW-1:0] tail_reg [NUM_LEVELS];
    logic [CW-1:0] count_reg [NUM_LEVELS];

    // per-id tables
    logic [BURST_BITS-1:0] rem_mem [MAX_PROCS];
    logic [1:0]            lvl_mem [MAX_PROCS];

    logic        runner_valid_reg;
    logic [3:0]  runner_id_reg;
    logic [7:0]  slice_reg;
    logic [31:0] tick_reg;
    logic [15:0] countdown_reg;

    // item and result registers
    logic        func_reg;
    logic [3:0]  pid_reg;
    logic [15:0] burst_reg;
    logic        ovf_reg, boosted_reg, pre_reg, disp_reg, fin_reg, dem_reg, idle_reg;
    logic [3:0]  rid_reg, preid_reg;
    logic [1:0]  rlev_reg;
    logic [3:0]  pop_id_reg;
    logic [BURST_BITS-1:0] rem_rd_reg;
    logic        out_valid_reg;

    // table slot of an id: the id taken modulo MAX_PROCS, built as a small lookup
    function automatic logic [PW-1:0] slot_of(logic [3:0] id);
        logic [PW-1:0] s;
        s = '0;
        for (int k = 0; k < 16; k++) begin
            if (id == 4'(k)) s = PW'(k % MAX_PROCS);
        end
        return s;
    endfunction

    logic [PW-1:0] runner_slot, pid_slot;
    assign runner_slot = slot_of(runner_id_reg);
    assign pid_slot    = slot_of(pid_reg);

    logic [NUM_LEVELS-1:0] nonempty;
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) nonempty[l] = (count_reg[l] != '0);
    end

    logic [1:0] run_lvl;
    assign run_lvl = (lvl_mem[runner_slot] > 2'd2) ? 2'd2 : lvl_mem[runner_slot];

    logic higher;
    assign higher = (run_lvl == 2'd1 && nonempty[0]) ||
                    (run_lvl == 2'd2 && (nonempty[0] || nonempty[1]));

    logic [1:0] top_lvl;
    assign top_lvl = nonempty[0] ? 2'd0 : (nonempty[1] ? 2'd1 : 2'd2);

    assign stat.is_tick      = func_reg;
    assign stat.boost_due    = boosted_reg;
    assign stat.lower_busy   = nonempty[1] || nonempty[2];
    assign stat.any_work     = |nonempty;
    assign stat.runner_valid = runner_valid_reg;
    assign stat.out_busy     = out_valid_reg;

    // one push port and one pop port on the rings per cycle
    logic       push_en;
    logic [1:0] push_lvl;
    logic [3:0] push_id;
    logic       pop_en;
    logic [1:0] pop_lvl;

    always_comb begin
        push_en  = 1'b0;
        push_lvl = 2'd0;
        push_id  = runner_id_reg;
        pop_en   = 1'b0;
        pop_lvl  = nonempty[1] ? 2'd1 : 2'd2;
        if (cmd.arrive) begin
            push_en = 1'b1;
            push_id = pid_reg;
        end
        if (cmd.boost_runner && runner_valid_reg) push_en = 1'b1;
        if (cmd.boost_pop) pop_en = 1'b1;
        if (cmd.boost_push) begin
            push_en = 1'b1;
            push_id = pop_id_reg;
        end
        if (cmd.preempt && runner_valid_reg && higher) begin
            push_en  = 1'b1;
            push_lvl = run_lvl;
        end
        if (cmd.dispatch && !runner_valid_reg && (|nonempty)) begin
            pop_en  = 1'b1;
            pop_lvl = top_lvl;
        end
        if (cmd.serve_wb && !idle_reg && !fin_reg && dem_reg) begin
            push_en  = 1'b1;
            push_lvl = rlev_reg;
        end
    end

    logic push_full;
    assign push_full = (count_reg[push_lvl] >= CW'(MAX_PROCS));

    always_ff @(posedge aclk) begin
        if (push_en && !push_full) ring_mem[push_lvl][tail_reg[push_lvl]] <= push_id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                logic do_push, do_pop;
                do_push = push_en && !push_full && (push_lvl == 2'(l));
                do_pop  = pop_en && (pop_lvl == 2'(l));
                if (do_push) begin
                    tail_reg[l] <= (tail_reg[l] == PW'(MAX_PROCS - 1)) ? '0 : tail_reg[l] + 1'b1;
                end
                if (do_pop) begin
                    head_reg[l] <= (head_reg[l] == PW'(MAX_PROCS - 1)) ? '0 : head_reg[l] + 1'b1;
                end
                if (do_push && !do_pop) count_reg[l] <= count_reg[l] + 1'b1;
                else if (do_pop && !do_push) count_reg[l] <= count_reg[l] - 1'b1;
            end
        end
    end

    logic [3:0] pop_data;
    assign pop_data = ring_mem[pop_lvl][head_reg[pop_lvl]];

    // id tables
    logic [PW-1:0] pop_slot;
    assign pop_slot = slot_of(pop_id_reg);

    always_ff @(posedge aclk) begin
        if (cmd.arrive) begin
            lvl_mem[pid_slot] <= 2'd0;
            rem_mem[pid_slot] <= BURST_BITS'(burst_reg);
        end
        if (cmd.boost_runner && runner_valid_reg) lvl_mem[runner_slot] <= 2'd0;
        if (cmd.boost_push) lvl_mem[pop_slot] <= 2'd0;
        if (cmd.serve_wb && !idle_reg) begin
            if (fin_reg) rem_mem[runner_slot] <= '0;
            else rem_mem[runner_slot] <= rem_rd_reg - 1'b1;
            if (dem_reg) lvl_mem[runner_slot] <= rlev_reg;
        end
    end

    logic [7:0] q_sel;
    always_comb begin
        case (run_lvl)
            2'd0:    q_sel = quantum_reg[0];
            2'd1:    q_sel = quantum_reg[1];
            default: q_sel = quantum_reg[2];
        endcase
    end

    // control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boost_period_reg <= '0;
            quantum_reg[0]   <= 8'd2;
            quantum_reg[1]   <= 8'd4;
            quantum_reg[2]   <= 8'd8;
            runner_valid_reg <= 1'b0;
            runner_id_reg    <= '0;
            slice_reg        <= '0;
            tick_reg         <= '0;
            countdown_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_idx))
                    CFG_BOOST_PERIOD: begin
                        boost_period_reg <= cfg_data;
                        countdown_reg    <= '0;
                    end
                    CFG_QUANTUM_L0: quantum_reg[0] <= cfg_data[7:0];
                    CFG_QUANTUM_L1: quantum_reg[1] <= cfg_data[7:0];
                    CFG_QUANTUM_L2: quantum_reg[2] <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (cmd.present) out_valid_reg <= 1'b1;
            if (cmd.boost_tick) begin
                if (boost_period_reg == '0) countdown_reg <= '0;
                else if (countdown_reg == '0) countdown_reg <= boost_period_reg;
                else if (countdown_reg == 16'd1) countdown_reg <= boost_period_reg;
                else countdown_reg <= countdown_reg - 1'b1;
            end
            if (cmd.boost_runner) begin
                runner_valid_reg <= 1'b0;
                slice_reg        <= '0;
            end
            if (cmd.preempt && runner_valid_reg && higher) begin
                runner_valid_reg <= 1'b0;
                slice_reg        <= '0;
            end
            if (cmd.dispatch && !runner_valid_reg && (|nonempty)) begin
                runner_id_reg    <= pop_data;
                runner_valid_reg <= 1'b1;
            end
            if (cmd.disp_load && disp_reg) begin
                slice_reg <= (q_sel == '0) ? 8'd1 : q_sel;
            end
            if (cmd.serve) begin
                tick_reg <= tick_reg + 1'b1;
                if (runner_valid_reg) begin
                    if (rem_rd_reg <= BURST_BITS'(1)) begin
                        runner_valid_reg <= 1'b0;
                        slice_reg        <= '0;
                    end else begin
                        slice_reg <= (slice_reg == '0) ? '0 : slice_reg - 1'b1;
                        if (slice_reg <= 8'd1) runner_valid_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // item capture, per-item flags and table read registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= in_func;
            pid_reg     <= in_proc_id;
            burst_reg   <= in_burst;
            ovf_reg     <= 1'b0;
            boosted_reg <= 1'b0;
            pre_reg     <= 1'b0;
            preid_reg   <= '0;
            disp_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            dem_reg     <= 1'b0;
            idle_reg    <= 1'b0;
            rid_reg     <= '0;
            rlev_reg    <= '0;
        end
        if (push_en && push_full) ovf_reg <= 1'b1;
        if (cmd.boost_tick) begin
            boosted_reg <= (boost_period_reg != '0) && (countdown_reg == 16'd1);
        end
        if (cmd.boost_pop) begin
            pop_id_reg <= pop_data;
        end
        if (cmd.preempt && runner_valid_reg && higher) begin
            pre_reg   <= 1'b1;
            preid_reg <= runner_id_reg;
        end
        if (cmd.dispatch && !runner_valid_reg && (|nonempty)) disp_reg <= 1'b1;
        if (cmd.disp_load) begin
            rem_rd_reg <= rem_mem[runner_slot];
        end
        if (cmd.serve) begin
            if (!runner_valid_reg) begin
                idle_reg <= 1'b1;
            end else begin
                rid_reg <= runner_id_reg;
                if (rem_rd_reg <= BURST_BITS'(1)) begin
                    fin_reg  <= 1'b1;
                    rlev_reg <= run_lvl;
                end else if (slice_reg <= 8'd1) begin
                    dem_reg  <= 1'b1;
                    rlev_reg <= (run_lvl < 2'd2) ? run_lvl + 2'd1 : 2'd2;
                end else begin
                    rlev_reg <= run_lvl;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {tick_reg, dem_reg, fin_reg, disp_reg, preid_reg, pre_reg,
                        boosted_reg, rlev_reg, rid_reg, idle_reg, ovf_reg};

endmodule

[rtl/mlfq_three_level_scheduler_top.sv]
// Top level of the three-level feedback-queue scheduler.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_dp.
//
// One item is taken at a time. An arrival is pushed to level 0 and its result
// presented; a tick runs the boost check, the preemption check, dispatch, the
// table read, the service step and its write-back before its result is shown,
// and a tick that boosts first moves the runner and every entry of levels 1
// and 2 into level 0. The boost walk, one ring pop and one push per entry
// through single ring ports, sets the longest case. A new item is taken in
// the cycle after the previous result has been transferred.
module mlfq_three_level_scheduler_top import mlfq_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // proc_id[3:0], burst[19:4], zero fill[23:20]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // queue_overflow, cpu_idle, run_id, run_level, boosted,
                                   // preempted, preempted_id, dispatched, finished,
                                   // demoted, time_now, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t stat;
    logic [48:0] res;

    mlfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlfq_dp #(.MAX_PROCS(MAX_PROCS), .BURST_BITS(BURST_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tuser),
        .in_proc_id (s_tdata[3:0]),
        .in_burst   (s_tdata[19:4]),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res)
    );

    assign m_tdata = {7'd0, res};

endmodule

[rtl/mlfq_checker.sv]
// Port-level checker for the scheduler top, attached by bind.
// Depends on nothing but the top level's ports.
module mlfq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a result stays until transferred
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // no new item while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    // idle tick reports no runner
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[5:2] == 4'd0 && !m_tdata[15] && !m_tdata[16])
        else $error("idle tick with runner fields");

    // finish and demotion exclude each other
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[15] && m_tdata[16]))
        else $error("finished and demoted together");

endmodule

bind mlfq_three_level_scheduler_top mlfq_checker u_mlfq_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for mlfq_three_level_scheduler_top: directed and random
// arrivals and ticks, checked against a scheduler predictor kept in this module.
// Depends on mlfq_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mlfq_pkg::*;

    localparam int NPROC      = 16;
    localparam int DRAIN_WAIT = 10 + 4 * NPROC + 16;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        func_t       func;
        logic [3:0]  pid;
        logic [15:0] burst;
    } sched_item_t;

    typedef struct {
        logic        ovf;
        logic        idle;
        logic [3:0]  run_id;
        logic [1:0]  run_level;
        logic        boosted;
        logic        preempted;
        logic [3:0]  preempted_id;
        logic        dispatched;
        logic        finished;
        logic        demoted;
        logic [31:0] time_now;
    } sched_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    mlfq_three_level_scheduler_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // Scheduler state mirrored by the predictor.
    logic [3:0]  ring_ids [3][NPROC];
    int          ring_head [3];
    int          ring_tail [3];
    int          ring_cnt [3];
    logic [15:0] ticks_left [NPROC];
    logic [1:0]  proc_level [NPROC];
    logic        cpu_busy;
    logic [3:0]  cpu_id;
    logic [7:0]  slice_cnt;
    logic [31:0] tick_total;
    logic [15:0] boost_cnt;
    logic [15:0] boost_every;
    logic [7:0]  quantum [3];

    sched_item_t   pending_items[$];
    sched_result_t expected_results[$];
    int            errors;
    bit            gaps_on;
    bit            took_item;
    int            src_gap;
    int            sink_stall;
    longint        cycle_count;

    function automatic bit ring_push(int lv, logic [3:0] id);
        if (ring_cnt[lv] >= NPROC) return 1'b0;
        ring_ids[lv][ring_tail[lv]] = id;
        ring_tail[lv] = (ring_tail[lv] + 1) % NPROC;
        ring_cnt[lv]++;
        return 1'b1;
    endfunction

    function automatic logic [3:0] ring_pop(int lv);
        logic [3:0] id;
        id = ring_ids[lv][ring_head[lv]];
        ring_head[lv] = (ring_head[lv] + 1) % NPROC;
        ring_cnt[lv]--;
        return id;
    endfunction

    function automatic logic [7:0] slice_for(int lv);
        return (quantum[lv] == 8'd0) ? 8'd1 : quantum[lv];
    endfunction

    // Advance the scheduler by one item and return what the block must report.
    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t r;
        logic [3:0] id;
        int lv;
        bit higher;
        r = '{default: '0};
        if (it.func == FUNC_ARRIVAL) begin
            proc_level[it.pid] = 2'd0;
            ticks_left[it.pid] = it.burst;
            if (!ring_push(0, it.pid)) r.ovf = 1'b1;
        end else begin
            if (boost_every == 16'd0) begin
                boost_cnt = 16'd0;
            end else if (boost_cnt == 16'd0) begin
                boost_cnt = boost_every;
            end else begin
                boost_cnt--;
                if (boost_cnt == 16'd0) begin
                    r.boosted = 1'b1;
                    boost_cnt = boost_every;
                end
            end
            if (r.boosted) begin
                if (cpu_busy) begin
                    proc_level[cpu_id] = 2'd0;
                    if (!ring_push(0, cpu_id)) r.ovf = 1'b1;
                    cpu_busy = 1'b0;
                    slice_cnt = 8'd0;
                end
                for (int l = 1; l <= 2; l++) begin
                    while (ring_cnt[l] != 0) begin
                        id = ring_pop(l);
                        proc_level[id] = 2'd0;
                        if (!ring_push(0, id)) r.ovf = 1'b1;
                    end
                end
            end
            if (cpu_busy) begin
                lv = proc_level[cpu_id];
                higher = (lv == 1 && ring_cnt[0] != 0) ||
                         (lv == 2 && (ring_cnt[0] != 0 || ring_cnt[1] != 0));
                if (higher) begin
                    if (!ring_push(lv, cpu_id)) r.ovf = 1'b1;
                    r.preempted = 1'b1;
                    r.preempted_id = cpu_id;
                    cpu_busy = 1'b0;
                    slice_cnt = 8'd0;
                end
            end
            if (!cpu_busy) begin
                for (int l = 0; l <= 2; l++) begin
                    if (!cpu_busy && ring_cnt[l] != 0) begin
                        cpu_id = ring_pop(l);
                        cpu_busy = 1'b1;
                        r.dispatched = 1'b1;
                        slice_cnt = slice_for(proc_level[cpu_id]);
                    end
                end
            end
            tick_total++;
            if (!cpu_busy) begin
                r.idle = 1'b1;
            end else begin
                lv = proc_level[cpu_id];
                r.run_id = cpu_id;
                if (ticks_left[cpu_id] <= 16'd1) begin
                    ticks_left[cpu_id] = 16'd0;
                    r.finished = 1'b1;
                    cpu_busy = 1'b0;
                    slice_cnt = 8'd0;
                end else begin
                    ticks_left[cpu_id]--;
                    if (slice_cnt != 8'd0) slice_cnt--;
                    if (slice_cnt == 8'd0) begin
                        if (lv < 2) lv++;
                        proc_level[cpu_id] = lv[1:0];
                        if (!ring_push(lv, cpu_id)) r.ovf = 1'b1;
                        r.demoted = 1'b1;
                        cpu_busy = 1'b0;
                    end
                end
                r.run_level = lv[1:0];
            end
        end
        r.time_now = tick_total;
        return r;
    endfunction

    function automatic sched_result_t unpack_result(logic [55:0] d);
        sched_result_t r;
        r.ovf          = d[0];
        r.idle         = d[1];
        r.run_id       = d[5:2];
        r.run_level    = d[7:6];
        r.boosted      = d[8];
        r.preempted    = d[9];
        r.preempted_id = d[13:10];
        r.dispatched   = d[14];
        r.finished     = d[15];
        r.demoted      = d[16];
        r.time_now     = d[48:17];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                     exp_v, act_v);
            errors++;
        end
    endtask

    // Clock and cycle limit.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Predict on every input transfer; check every output transfer.
    always @(posedge aclk) begin
        sched_item_t   it;
        sched_result_t exp_r;
        sched_result_t act_r;
        took_item = aresetn && s_tvalid && s_tready;
        if (took_item) begin
            it.func  = func_t'(s_tuser);
            it.pid   = s_tdata[3:0];
            it.burst = s_tdata[19:4];
            expected_results.push_back(schedule_step(it));
        end
        if (aresetn && m_tvalid && m_tready) begin
            act_r = unpack_result(m_tdata);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, actual %0h", $realtime, m_tdata);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("queue_overflow", 32'(exp_r.ovf), 32'(act_r.ovf));
                check_field("cpu_idle", 32'(exp_r.idle), 32'(act_r.idle));
                check_field("run_id", 32'(exp_r.run_id), 32'(act_r.run_id));
                check_field("run_level", 32'(exp_r.run_level), 32'(act_r.run_level));
                check_field("boosted", 32'(exp_r.boosted), 32'(act_r.boosted));
                check_field("preempted", 32'(exp_r.preempted), 32'(act_r.preempted));
                check_field("preempted_id", 32'(exp_r.preempted_id),
                            32'(act_r.preempted_id));
                check_field("dispatched", 32'(exp_r.dispatched), 32'(act_r.dispatched));
                check_field("finished", 32'(exp_r.finished), 32'(act_r.finished));
                check_field("demoted", 32'(exp_r.demoted), 32'(act_r.demoted));
                check_field("time_now", exp_r.time_now, act_r.time_now);
                check_field("zero fill", 32'd0, 32'(m_tdata[55:49]));
            end
        end
    end

    // Source: drop valid after a transfer, then either hold off a burst or
    // present the next pending item.
    always @(negedge aclk) begin
        logic        nxt_valid;
        sched_item_t it;
        nxt_valid = s_tvalid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && took_item) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() != 0) begin
                    if (gaps_on && $urandom_range(0, 3) == 0) begin
                        src_gap = $urandom_range(0, 4);
                    end else begin
                        it = pending_items.pop_front();
                        s_tuser    <= it.func;
                        s_tdata    <= {4'd0, it.burst, it.pid};
                        nxt_valid  = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Sink: stall in random bursts.
    always @(negedge aclk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (sink_stall > 0) begin
            sink_stall--;
            nxt_ready = 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            sink_stall = $urandom_range(0, 4);
            nxt_ready = 1'b0;
        end
        m_tready <= nxt_ready;
    end

    task automatic add_item(func_t f, logic [3:0] id, logic [15:0] b);
        sched_item_t it;
        it.func  = f;
        it.pid   = id;
        it.burst = b;
        pending_items.push_back(it);
    endtask

    // Hold until every queued item has been sent and answered, then let the
    // sequencer settle.
    task automatic drain;
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_BOOST_PERIOD: begin
                boost_every = val;
                boost_cnt   = 16'd0;
            end
            CFG_QUANTUM_L0: quantum[0] = val[7:0];
            CFG_QUANTUM_L1: quantum[1] = val[7:0];
            CFG_QUANTUM_L2: quantum[2] = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small bursts so that processes finish, demote and get preempted;
    // now and then a long one that sinks to level 2.
    task automatic add_random(int n);
        logic [15:0] b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                b = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
                add_item(FUNC_ARRIVAL, 4'($urandom_range(0, 15)), b);
            end else begin
                add_item(FUNC_TICK, 4'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_BOOST_PERIOD;
        cfg_data    = '0;
        errors      = 0;
        gaps_on     = 1'b1;
        took_item   = 1'b0;
        src_gap     = 0;
        sink_stall  = 0;
        cycle_count = 0;
        for (int l = 0; l < 3; l++) begin
            ring_head[l] = 0;
            ring_tail[l] = 0;
            ring_cnt[l]  = 0;
        end
        cpu_busy    = 1'b0;
        cpu_id      = '0;
        slice_cnt   = '0;
        tick_total  = '0;
        boost_cnt   = '0;
        boost_every = '0;
        quantum[0]  = 8'd2;
        quantum[1]  = 8'd4;
        quantum[2]  = 8'd8;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: idle tick, zero and maximum bursts, a repeated id, then
        // overfill level 0 and tick through demotion and finishing.
        add_item(FUNC_TICK, 4'h0, 16'h0000);
        add_item(FUNC_ARRIVAL, 4'hF, 16'hFFFF);
        add_item(FUNC_ARRIVAL, 4'h0, 16'h0000);
        add_item(FUNC_ARRIVAL, 4'h5, 16'd3);
        for (int i = 0; i < 14; i++) add_item(FUNC_ARRIVAL, 4'(i), 16'(i + 2));
        add_item(FUNC_ARRIVAL, 4'h5, 16'd7);
        for (int i = 0; i < 6; i++) add_item(FUNC_TICK, 4'hF, 16'hFFFF);
        drain();

        // Frequent boosts with one-tick slices.
        write_reg(CFG_BOOST_PERIOD, 16'd3);
        write_reg(CFG_QUANTUM_L0, 16'd1);
        write_reg(CFG_QUANTUM_L1, 16'd1);
        write_reg(CFG_QUANTUM_L2, 16'd1);
        add_random(150);
        drain();

        // Longest slices and a boost period too long to fire.
        write_reg(CFG_BOOST_PERIOD, 16'hFFFF);
        write_reg(CFG_QUANTUM_L0, 16'd255);
        write_reg(CFG_QUANTUM_L1, 16'd255);
        write_reg(CFG_QUANTUM_L2, 16'd255);
        add_random(100);
        drain();

        // Zero quanta act as one; boosting off.
        write_reg(CFG_BOOST_PERIOD, 16'd0);
        write_reg(CFG_QUANTUM_L0, 16'd0);
        write_reg(CFG_QUANTUM_L1, 16'd0);
        write_reg(CFG_QUANTUM_L2, 16'd0);
        add_random(100);
        drain();

        // Mixed settings, then a final stretch with both sides always ready.
        write_reg(CFG_BOOST_PERIOD, 16'd11);
        write_reg(CFG_QUANTUM_L0, 16'd2);
        write_reg(CFG_QUANTUM_L1, 16'd3);
        write_reg(CFG_QUANTUM_L2, 16'd5);
        add_random(150);
        drain();
        gaps_on = 1'b0;
        add_random(80);
        drain();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/mlfq_pkg.sv
rtl/mlfq_ctrl.sv
rtl/mlfq_dp.sv
rtl/mlfq_three_level_scheduler_top.sv
rtl/mlfq_checker.sv
verif/testbench.sv
